/* sv/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and defaults for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_SEMS_DEF   = 16;
  localparam int COUNT_BITS_DEF = 16;

  // opcodes
  localparam logic [2:0] OP_OPEN  = 3'd0;
  localparam logic [2:0] OP_CLOSE = 3'd1;
  localparam logic [2:0] OP_UP    = 3'd2;
  localparam logic [2:0] OP_DOWN  = 3'd3;
  localparam logic [2:0] OP_ALLOC = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_CLOSED    = 3'd2;
  localparam logic [2:0] ST_BLOCK     = 3'd3;
  localparam logic [2:0] ST_NONE_FREE = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  sem_index;
    logic [15:0] start_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  granted_index;
    logic        wake;
    logic [15:0] count_after;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch request, launch entry read
    logic commit;  // apply update, load result register
  } cst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new item this cycle
  } cst_stat_t;

endpackage

/* sv/cst_ctrl.sv */
// ----------------------------------------------------------------------------
// cst_ctrl
// Two-state sequencer: accept a request, then execute and commit it.
// ----------------------------------------------------------------------------
module cst_ctrl
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cst_stat_t stat,
  output cst_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // hold here while an earlier result is still stalled
        cmd.commit = stat.out_free;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* sv/cst_dp.sv */
// ----------------------------------------------------------------------------
// cst_dp
// Count memory, open and written flags, free-entry encoder, result register.
// ----------------------------------------------------------------------------
module cst_dp
  import cst_pkg::*;
#(
  parameter int NUM_SEMS   = NUM_SEMS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cst_cmd_t  cmd,
  output cst_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [6:0] NUM_SEMS_V = 7'(NUM_SEMS);

  logic [COUNT_BITS-1:0] mem [NUM_SEMS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [NUM_SEMS-1:0]   open_r, written_r;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic                  any_free_r, any_free_nxt;
  in_item_t              req_r;
  logic [IDX_W-1:0]      addr_r;
  logic                  out_valid_r;
  out_item_t             out_data_r, res;

  logic                  in_range;
  logic [IDX_W-1:0]      rd_addr;

  assign in_range = {1'b0, in_data.sem_index} < NUM_SEMS_V;
  assign rd_addr  = in_range ? in_data.sem_index[IDX_W-1:0] : '0;

  // lowest closed entry, registered
  always_comb begin
    free_idx_nxt = '0;
    any_free_nxt = 1'b0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!open_r[i]) begin
        free_idx_nxt = IDX_W'(i);
        any_free_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    any_free_r <= any_free_nxt;
  end

  // request latch and registered entry read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r     <= in_data;
      addr_r    <= rd_addr;
      rd_data_r <= mem[rd_addr];
    end
  end

  // execute
  logic [COUNT_BITS-1:0] cur, wdata;
  logic [IDX_W-1:0]      waddr;
  logic                  we, set_open, clr_open, req_range;
  logic [31:0]           start_w, max_w, cnt_w;
  logic [COUNT_BITS-1:0] start_c;

  always_comb begin
    cur       = written_r[addr_r] ? rd_data_r : '0;
    start_w   = 32'(req_r.start_value);
    max_w     = 32'(CNT_MAX);
    start_c   = (start_w > max_w) ? CNT_MAX : start_w[COUNT_BITS-1:0];
    req_range = {1'b0, req_r.sem_index} < NUM_SEMS_V;
    we        = 1'b0;
    set_open  = 1'b0;
    clr_open  = 1'b0;
    waddr     = addr_r;
    wdata     = start_c;
    cnt_w     = '0;
    res       = '0;
    res.status = ST_OK;
    if (req_r.opcode == OP_ALLOC) begin
      if (any_free_r) begin
        waddr             = free_idx_r;
        we                = 1'b1;
        set_open          = 1'b1;
        res.granted_index = 6'(free_idx_r);
        cnt_w             = 32'(start_c);
      end else begin
        res.status = ST_NONE_FREE;
      end
    end else if (!req_range) begin
      res.status = ST_RANGE;
    end else begin
      unique case (req_r.opcode)
        OP_OPEN: begin
          we       = 1'b1;
          set_open = 1'b1;
          cnt_w    = 32'(start_c);
        end
        OP_CLOSE: begin
          clr_open = 1'b1;
          cnt_w    = 32'(cur);
        end
        OP_UP: begin
          if (!open_r[addr_r]) begin
            res.status = ST_CLOSED;
            cnt_w      = 32'(cur);
          end else begin
            res.wake = (cur == '0);
            wdata    = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);
            we       = 1'b1;
            cnt_w    = 32'(wdata);
          end
        end
        OP_DOWN: begin
          if (!open_r[addr_r]) begin
            res.status = ST_CLOSED;
            cnt_w      = 32'(cur);
          end else if (cur == '0) begin
            res.status = ST_BLOCK;
          end else begin
            wdata = cur - COUNT_BITS'(1);
            we    = 1'b1;
            cnt_w = 32'(wdata);
          end
        end
        default: res.status = ST_RANGE;  // undefined opcodes
      endcase
    end
    res.count_after = cnt_w[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= '0;
      written_r <= '0;
    end else if (cmd.commit) begin
      if (we)       written_r[waddr] <= 1'b1;
      if (set_open) open_r[waddr]    <= 1'b1;
      if (clr_open) open_r[waddr]    <= 1'b0;
    end
  end

  // result register
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/counting_semaphore_table.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Bank of counting semaphores: open, close, up, down and allocate-lowest-free.
// ----------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_item_t  (opcode, index, start)
//   out_     output     out_valid/out_stall out_item_t (status, grant, wake, count)
//
// Each item is accepted in S_IDLE, launching the registered read of the addressed
// count; S_EXEC, once the result register has room, computes the update, writes
// it back and loads the result register. One item is worked at a time.
// Reset (rst_n low, synchronous) clears all open and written flags; counts of
// never-written entries read as zero, so no clearing pass is needed.
// A stalled result holds the execute step; a new item may still be accepted
// while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module counting_semaphore_table
  import cst_pkg::*;
#(
  parameter int NUM_SEMS   = NUM_SEMS_DEF,   // 1..64 entries
  parameter int COUNT_BITS = COUNT_BITS_DEF  // 1..32 count width
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cst_cmd_t  cmd;   // accept / commit strobes
  cst_stat_t stat;  // result register has room

  // sequencer
  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counts, flags, free-entry encoder and result register
  cst_dp #(
    .NUM_SEMS   (NUM_SEMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* sv/cst_checker.sv */
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks for the counting semaphore table, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker
  import cst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  // wake only on a successful up from zero
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wake |-> out_data.status == ST_OK && out_data.count_after == 16'd1)
    else $error("bad wake");

  // a grant only comes with ok status
  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.granted_index != 6'd0 |-> out_data.status == ST_OK)
    else $error("grant without ok");

  // none free carries no count
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NONE_FREE |-> out_data.count_after == 16'd0)
    else $error("none free with count");

endmodule

bind counting_semaphore_table cst_checker u_cst_checker (.*);
